>>> hdl/mwc_pkg.sv
// Shared types and constants for the microwave oven controller.
// No dependencies; imported by every module of the block and by its checker.
package mwc_pkg;

    // Event codes carried in s_tuser
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_POWER   = 3'd3;
    localparam logic [2:0] CMD_MODE    = 3'd4;
    localparam logic [2:0] CMD_DEFROST = 3'd5;
    localparam logic [2:0] CMD_CLOCK   = 3'd6;
    localparam logic [2:0] CMD_DIAL    = 3'd7;

    // Controller phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HOURS    = 3'd1;
    localparam logic [2:0] PH_MINUTES  = 3'd2;
    localparam logic [2:0] PH_POWER    = 3'd3;
    localparam logic [2:0] PH_COOKTIME = 3'd4;
    localparam logic [2:0] PH_COOKING  = 3'd5;
    localparam logic [2:0] PH_MODE     = 3'd6;
    localparam logic [2:0] PH_DEFROST  = 3'd7;

    // Limits and fixed amounts
    localparam logic [5:0] SEC_MAX        = 6'd59;
    localparam logic [4:0] HOUR_MAX       = 5'd23;
    localparam logic [6:0] COOK_MIN_MAX   = 7'd99;
    localparam logic [5:0] QUICK_SEC      = 6'd30;
    localparam logic [4:0] POWER_DIAL_MAX = 5'd20;
    localparam logic [7:0] POWER_MAX      = 8'd200;
    localparam logic [1:0] MODE_MAX       = 2'd3;
    localparam logic [5:0] DEFROST_MIN    = 6'd15;

    // One input beat
    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] dial_value;
        logic [5:0] defrost_seconds;
    } mwc_in_t;

    // One result beat
    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [6:0] cook_minutes;
        logic [5:0] cook_seconds;
        logic [7:0] power_level;
        logic [1:0] cook_mode;
        logic       heating;
        logic       done_res;
    } mwc_res_t;

endpackage

>>> hdl/mwc_in_reg.sv
// Input register of the microwave oven controller: holds one accepted event beat.
// Depends on mwc_pkg.
module mwc_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mwc_pkg::mwc_in_t in_beat,
    output logic             in_ready,
    input  logic             advance,
    output logic             valid,
    output mwc_pkg::mwc_in_t beat
);
    import mwc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    mwc_in_t beat_reg;

    // Take a new beat when empty or when the held one moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

>>> hdl/mwc_fsm.sv
// Controller state and next-state logic: phase, time of day, cook countdown, settings.
// Depends on mwc_pkg; produces the result of the event it is handed.
module mwc_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  mwc_pkg::mwc_in_t  beat,
    output mwc_pkg::mwc_res_t res
);
    import mwc_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [6:0] cook_min_reg, cook_min_next;
    logic [5:0] cook_sec_reg, cook_sec_next;
    logic [7:0] power_reg, power_next;
    logic [1:0] mode_reg, mode_next;
    logic       from_idle_reg, from_idle_next;
    logic       from_setup_reg, from_setup_next;
    logic       done;

    always_comb
    begin
        logic [5:0] dsec;
        logic       go;
        logic [2:0] target;
        logic [4:0] pdial;

        phase_next      = phase_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        cook_min_next   = cook_min_reg;
        cook_sec_next   = cook_sec_reg;
        power_next      = power_reg;
        mode_next       = mode_reg;
        from_idle_next  = from_idle_reg;
        from_setup_next = from_setup_reg;
        done            = 1'b0;
        go              = 1'b0;
        target          = PH_IDLE;
        pdial           = 5'd0;

        // Clamp the defrost seconds
        if (beat.defrost_seconds < DEFROST_MIN)
        begin
            dsec = DEFROST_MIN;
        end
        else if (beat.defrost_seconds > SEC_MAX)
        begin
            dsec = SEC_MAX;
        end
        else
        begin
            dsec = beat.defrost_seconds;
        end

        unique case (beat.cmd)
            CMD_TICK:
            begin
                // Advance the time of day
                if (second_reg < SEC_MAX)
                begin
                    second_next = second_reg + 6'd1;
                end
                else
                begin
                    second_next = 6'd0;
                    if (minute_reg < SEC_MAX)
                    begin
                        minute_next = minute_reg + 6'd1;
                    end
                    else
                    begin
                        minute_next = 6'd0;
                        hour_next   = (hour_reg < HOUR_MAX) ? hour_reg + 5'd1 : 5'd0;
                    end
                end
                // Count the cook time down, end cooking at zero
                if (phase_reg == PH_COOKING)
                begin
                    if (cook_sec_reg != 6'd0)
                    begin
                        cook_sec_next = cook_sec_reg - 6'd1;
                        if (cook_sec_reg == 6'd1 && cook_min_reg == 7'd0)
                        begin
                            done = 1'b1;
                        end
                    end
                    else if (cook_min_reg == 7'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        cook_min_next = cook_min_reg - 7'd1;
                        cook_sec_next = SEC_MAX;
                    end
                    if (done)
                    begin
                        go     = 1'b1;
                        target = PH_IDLE;
                    end
                end
            end
            CMD_START:
            begin
                if (phase_reg == PH_COOKING)
                begin
                    // Add thirty seconds, saturate at the top
                    if (cook_sec_reg < QUICK_SEC)
                    begin
                        cook_sec_next = cook_sec_reg + QUICK_SEC;
                    end
                    else if (cook_min_reg < COOK_MIN_MAX)
                    begin
                        cook_min_next = cook_min_reg + 7'd1;
                        cook_sec_next = cook_sec_reg - QUICK_SEC;
                    end
                    else
                    begin
                        cook_sec_next = SEC_MAX;
                    end
                end
                else if (phase_reg == PH_IDLE || phase_reg == PH_COOKTIME ||
                         phase_reg == PH_DEFROST)
                begin
                    go     = 1'b1;
                    target = PH_COOKING;
                end
            end
            CMD_STOP:
            begin
                go     = 1'b1;
                target = PH_IDLE;
            end
            CMD_POWER:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    go     = 1'b1;
                    target = PH_POWER;
                end
                else if (phase_reg == PH_POWER)
                begin
                    go     = 1'b1;
                    target = PH_COOKTIME;
                end
            end
            CMD_MODE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    go     = 1'b1;
                    target = PH_MODE;
                end
                else if (phase_reg == PH_MODE)
                begin
                    go     = 1'b1;
                    target = PH_COOKTIME;
                end
            end
            CMD_DEFROST:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    go     = 1'b1;
                    target = PH_DEFROST;
                end
            end
            CMD_CLOCK:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    go     = 1'b1;
                    target = PH_HOURS;
                end
                else if (phase_reg == PH_HOURS)
                begin
                    go     = 1'b1;
                    target = PH_MINUTES;
                end
                else if (phase_reg == PH_MINUTES)
                begin
                    go     = 1'b1;
                    target = PH_IDLE;
                end
            end
            CMD_DIAL:
            begin
                // Write the setting of the current phase, saturated
                if (phase_reg == PH_HOURS)
                begin
                    hour_next = (beat.dial_value > 6'(HOUR_MAX)) ? HOUR_MAX
                                                                 : beat.dial_value[4:0];
                end
                else if (phase_reg == PH_MINUTES)
                begin
                    minute_next = (beat.dial_value > SEC_MAX) ? SEC_MAX : beat.dial_value;
                end
                else if (phase_reg == PH_POWER)
                begin
                    pdial = (beat.dial_value > 6'(POWER_DIAL_MAX)) ? POWER_DIAL_MAX
                                                                   : beat.dial_value[4:0];
                    power_next = {pdial, 3'b000} + {2'b00, pdial, 1'b0};
                end
                else if (phase_reg == PH_COOKTIME)
                begin
                    cook_sec_next = (beat.dial_value > SEC_MAX) ? SEC_MAX : beat.dial_value;
                end
                else if (phase_reg == PH_MODE)
                begin
                    mode_next = (beat.dial_value > 6'(MODE_MAX)) ? MODE_MAX
                                                                 : beat.dial_value[1:0];
                end
            end
            default:
            begin
            end
        endcase

        // Leave the current phase, then enter the target
        if (go)
        begin
            if (phase_reg == PH_IDLE)
            begin
                from_idle_next  = 1'b1;
                from_setup_next = 1'b0;
            end
            else if (phase_reg == PH_COOKTIME)
            begin
                from_idle_next  = 1'b0;
                from_setup_next = 1'b1;
            end
            else if (phase_reg == PH_DEFROST)
            begin
                from_idle_next  = 1'b0;
                from_setup_next = 1'b1;
                cook_min_next   = 7'd0;
                cook_sec_next   = dsec;
            end
            phase_next = target;
            if (target == PH_COOKING)
            begin
                if (from_idle_next)
                begin
                    cook_min_next  = 7'd0;
                    cook_sec_next  = QUICK_SEC;
                    from_idle_next = 1'b0;
                end
                else if (from_setup_next)
                begin
                    cook_min_next = 7'd0;
                end
            end
        end
    end

    // Commit the event when it moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hour_reg       <= 5'd0;
            minute_reg     <= 6'd0;
            second_reg     <= 6'd0;
            cook_min_reg   <= 7'd0;
            cook_sec_reg   <= 6'd0;
            power_reg      <= 8'd0;
            mode_reg       <= 2'd0;
            from_idle_reg  <= 1'b0;
            from_setup_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            cook_min_reg   <= cook_min_next;
            cook_sec_reg   <= cook_sec_next;
            power_reg      <= power_next;
            mode_reg       <= mode_next;
            from_idle_reg  <= from_idle_next;
            from_setup_reg <= from_setup_next;
        end
    end

    // Result shows the state after the event
    always_comb
    begin
        res.phase         = phase_next;
        res.clock_hours   = hour_next;
        res.clock_minutes = minute_next;
        res.cook_minutes  = cook_min_next;
        res.cook_seconds  = cook_sec_next;
        res.power_level   = power_next;
        res.cook_mode     = mode_next;
        res.heating       = (phase_next == PH_COOKING);
        res.done_res      = done;
    end

endmodule

>>> hdl/microwave_oven_controller.sv
// Top level of the microwave oven controller: input register, controller, result register.
// Depends on mwc_pkg, mwc_in_reg and mwc_fsm.

// The controller takes one event beat per clock cycle while the output is free and returns
// one result beat per event. The event is registered, then the controller's next-state
// logic works on it combinationally and the result register captures the state after the
// event; a result that waits on m_tready holds back only the beat in the input register,
// so one event per cycle is sustained while the output is taken.
module microwave_oven_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // dial_value[5:0], defrost_seconds[11:6], zero[15:12]
    input  logic [2:0]  s_tuser,  // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // phase[2:0], clock_hours[7:3], clock_minutes[13:8],
                                  // cook_minutes[20:14], cook_seconds[26:21],
                                  // power_level[34:27], cook_mode[36:35], heating[37],
                                  // done_res[38], zero[39]
);
    import mwc_pkg::*;

    mwc_in_t  in_beat;
    mwc_in_t  held_beat;
    logic     held_valid;
    logic     advance;
    mwc_res_t res;
    mwc_res_t res_reg;
    logic     m_tvalid_reg;
    logic     m_tvalid_next;

    // Unpack the slave beat
    assign in_beat.cmd             = s_tuser;
    assign in_beat.dial_value      = s_tdata[5:0];
    assign in_beat.defrost_seconds = s_tdata[11:6];

    // Move the held event on when the result register is free or draining
    assign advance = held_valid && (!m_tvalid_reg || m_tready);

    mwc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_beat  (in_beat),
        .in_ready (s_tready),
        .advance  (advance),
        .valid    (held_valid),
        .beat     (held_beat)
    );

    mwc_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .beat    (held_beat),
        .res     (res)
    );

    // Result register valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (advance)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.done_res, res_reg.heating, res_reg.cook_mode,
                       res_reg.power_level, res_reg.cook_seconds, res_reg.cook_minutes,
                       res_reg.clock_minutes, res_reg.clock_hours, res_reg.phase};

endmodule

>>> hdl/mwc_checker.sv
// Port-level checker for the microwave oven controller, bound to the top level.
// Depends on mwc_pkg; sees only the top level's ports.
module mwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import mwc_pkg::*;

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Heating follows the cooking phase
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[37] == (m_tdata[2:0] == PH_COOKING)))
        else $error("heating flag disagrees with phase");

    // A finished countdown leaves idle at 0:00
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[38] |->
            m_tdata[2:0] == PH_IDLE && m_tdata[20:14] == 7'd0 && m_tdata[26:21] == 6'd0)
        else $error("done without idle phase and empty countdown");

    // Settings stay within their ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] <= HOUR_MAX && m_tdata[13:8] <= SEC_MAX &&
                     m_tdata[26:21] <= SEC_MAX && m_tdata[34:27] <= POWER_MAX)
        else $error("field out of range");

endmodule

bind microwave_oven_controller mwc_checker u_mwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/microwave_oven_controller_tb.sv
// Self-checking testbench for microwave_oven_controller: drives event beats, predicts
// each result beat with a behavioral model of the oven and compares them field by field.
// Depends on mwc_pkg and the RTL of the block; needs no files or arguments.
module microwave_oven_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwc_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 100;
    localparam int TAIL_ITEMS       = 60;
    localparam int BURST_ITEMS      = 24;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES     = 4;
    localparam int MAX_REPORTS      = 10;
    localparam int COOK_TICK_CAP    = 130;
    localparam logic [7:0] POWER_STEP = 8'd10;

    typedef struct {
        logic [2:0] cmd;
        logic [5:0] dial;
        logic [5:0] thaw;
    } oven_event_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // dial_value[5:0], defrost_seconds[11:6], zero[15:12]
    logic [2:0]  s_tuser  = CMD_TICK;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // phase, clock_hours, clock_minutes, cook_minutes, cook_seconds,
                            // power_level, cook_mode, heating, done_res, zero

    // Oven state as predicted from the accepted events
    logic [2:0] oven_phase;
    logic [4:0] tod_hours;
    logic [5:0] tod_minutes;
    logic [5:0] tod_seconds;
    logic [6:0] cook_min;
    logic [5:0] cook_sec;
    logic [7:0] power_set;
    logic [1:0] mode_set;
    logic       from_idle;
    logic       from_setup;

    mwc_res_t pending_status[$];
    mwc_res_t last_status;
    int       useful_items = 0;
    int       mismatch_count = 0;
    bit       sender_gaps = 1'b1;
    bit       calm_tail = 1'b0;
    int       long_holds_asked = 0;
    int       long_holds_served = 0;

    microwave_oven_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Move to a new phase, applying the side effects of the phase being left
    function automatic void enter_phase(input logic [2:0] next, input logic [5:0] thaw);
        case (oven_phase)
            PH_IDLE:
            begin
                from_idle  = 1'b1;
                from_setup = 1'b0;
            end
            PH_COOKTIME:
            begin
                from_setup = 1'b1;
                from_idle  = 1'b0;
            end
            PH_DEFROST:
            begin
                from_idle  = 1'b0;
                from_setup = 1'b1;
                cook_min   = '0;
                cook_sec   = thaw;
            end
            default: ;
        endcase
        oven_phase = next;
        if (next == PH_COOKING)
        begin
            if (from_idle)
            begin
                cook_min  = '0;
                cook_sec  = QUICK_SEC;
                from_idle = 1'b0;
            end
            else if (from_setup)
                cook_min = '0;
        end
    endfunction

    // Apply one event to the oven state and return the status it leaves
    function automatic mwc_res_t apply_event(input logic [2:0] cmd, input logic [5:0] dial,
                                             input logic [5:0] thaw_raw);
        logic [5:0] thaw;
        bit         finished;
        mwc_res_t   st;
        thaw = (thaw_raw < DEFROST_MIN) ? DEFROST_MIN :
               (thaw_raw > SEC_MAX) ? SEC_MAX : thaw_raw;
        finished = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                // time of day runs in every phase
                if (tod_seconds < SEC_MAX)
                    tod_seconds = tod_seconds + 1'b1;
                else
                begin
                    tod_seconds = '0;
                    if (tod_minutes < SEC_MAX)
                        tod_minutes = tod_minutes + 1'b1;
                    else
                    begin
                        tod_minutes = '0;
                        tod_hours = (tod_hours < HOUR_MAX) ? tod_hours + 1'b1 : 5'd0;
                    end
                end
                // count the cook time down, borrowing from minutes at zero seconds
                if (oven_phase == PH_COOKING)
                begin
                    if (cook_sec != 0)
                    begin
                        cook_sec = cook_sec - 1'b1;
                        finished = (cook_sec == 0 && cook_min == 0);
                    end
                    else if (cook_min == 0)
                        finished = 1'b1;
                    else
                    begin
                        cook_min = cook_min - 1'b1;
                        cook_sec = SEC_MAX;
                    end
                    if (finished)
                        enter_phase(PH_IDLE, thaw);
                end
            end
            CMD_START:
            begin
                if (oven_phase == PH_COOKING)
                begin
                    // add half a minute, saturating at the top of the minute range
                    if (cook_sec < QUICK_SEC)
                        cook_sec = cook_sec + QUICK_SEC;
                    else if (cook_min < COOK_MIN_MAX)
                    begin
                        cook_min = cook_min + 1'b1;
                        cook_sec = cook_sec - QUICK_SEC;
                    end
                    else
                        cook_sec = SEC_MAX;
                end
                else if (oven_phase == PH_IDLE || oven_phase == PH_COOKTIME ||
                         oven_phase == PH_DEFROST)
                    enter_phase(PH_COOKING, thaw);
            end
            CMD_STOP:
                enter_phase(PH_IDLE, thaw);
            CMD_POWER:
            begin
                if (oven_phase == PH_IDLE)
                    enter_phase(PH_POWER, thaw);
                else if (oven_phase == PH_POWER)
                    enter_phase(PH_COOKTIME, thaw);
            end
            CMD_MODE:
            begin
                if (oven_phase == PH_IDLE)
                    enter_phase(PH_MODE, thaw);
                else if (oven_phase == PH_MODE)
                    enter_phase(PH_COOKTIME, thaw);
            end
            CMD_DEFROST:
            begin
                if (oven_phase == PH_IDLE)
                    enter_phase(PH_DEFROST, thaw);
            end
            CMD_CLOCK:
            begin
                if (oven_phase == PH_IDLE)
                    enter_phase(PH_HOURS, thaw);
                else if (oven_phase == PH_HOURS)
                    enter_phase(PH_MINUTES, thaw);
                else if (oven_phase == PH_MINUTES)
                    enter_phase(PH_IDLE, thaw);
            end
            default:
            begin
                // dial writes the setting of the current phase, saturated to its range
                case (oven_phase)
                    PH_HOURS:    tod_hours = (dial > HOUR_MAX) ? HOUR_MAX : dial[4:0];
                    PH_MINUTES:  tod_minutes = (dial > SEC_MAX) ? SEC_MAX : dial;
                    PH_POWER:    power_set = POWER_STEP *
                                             ((dial > POWER_DIAL_MAX) ? POWER_DIAL_MAX : dial);
                    PH_COOKTIME: cook_sec = (dial > SEC_MAX) ? SEC_MAX : dial;
                    PH_MODE:     mode_set = (dial > MODE_MAX) ? MODE_MAX : dial[1:0];
                    default: ;
                endcase
            end
        endcase
        st.phase         = oven_phase;
        st.clock_hours   = tod_hours;
        st.clock_minutes = tod_minutes;
        st.cook_minutes  = cook_min;
        st.cook_seconds  = cook_sec;
        st.power_level   = power_set;
        st.cook_mode     = mode_set;
        st.heating       = (oven_phase == PH_COOKING);
        st.done_res      = finished;
        return st;
    endfunction

    function automatic string status_text(input mwc_res_t st);
        return $sformatf({"phase=%0d clock=%0d:%0d cook=%0d:%0d power=%0d mode=%0d",
                          " heat=%0b done=%0b"},
                         st.phase, st.clock_hours, st.clock_minutes, st.cook_minutes,
                         st.cook_seconds, st.power_level, st.cook_mode, st.heating,
                         st.done_res);
    endfunction

    task automatic report_mismatch(input string what, input mwc_res_t want,
                                   input mwc_res_t seen);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s\n  expected %s\n  actual   %s", $realtime, what,
                     status_text(want), status_text(seen));
    endtask

    function automatic oven_event_t make_event(input logic [2:0] cmd, input logic [5:0] dial);
        oven_event_t ev;
        ev.cmd  = cmd;
        ev.dial = dial;
        ev.thaw = 6'($urandom_range(0, 63));
        return ev;
    endfunction

    function automatic logic [5:0] any_dial();
        return 6'($urandom_range(0, 63));
    endfunction

    // Cook-time dial: mostly short times so the countdown finishes often
    function automatic logic [5:0] short_dial();
        return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 15));
    endfunction

    // Offer one event beat, hold it until accepted, then record its expected status
    task automatic send_event(input logic [2:0] cmd, input logic [5:0] dial,
                              input logic [5:0] thaw);
        int       gap;
        mwc_res_t predicted;
        if (sender_gaps && !calm_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, thaw, dial};
        s_tuser  <= cmd;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predicted = apply_event(cmd, dial, thaw);
        if (cmd == CMD_TICK || predicted != last_status)
            useful_items++;
        last_status = predicted;
        pending_status.push_back(predicted);
    endtask

    // Drop valid and hold off until every expected beat has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One user session: a setup sequence, possibly cut short by stop, then any cooking it starts
    task automatic run_session();
        oven_event_t steps[$];
        int          cut;
        int          n;
        int          pick;
        sender_gaps = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0:
            begin
                steps.push_back(make_event(CMD_CLOCK, any_dial()));
                steps.push_back(make_event(CMD_DIAL, any_dial()));
                steps.push_back(make_event(CMD_CLOCK, any_dial()));
                steps.push_back(make_event(CMD_DIAL, any_dial()));
                steps.push_back(make_event(CMD_CLOCK, any_dial()));
            end
            1, 2:
            begin
                steps.push_back(make_event(CMD_POWER, any_dial()));
                steps.push_back(make_event(CMD_DIAL, any_dial()));
                steps.push_back(make_event(CMD_POWER, any_dial()));
                steps.push_back(make_event(CMD_DIAL, short_dial()));
                steps.push_back(make_event(CMD_START, any_dial()));
            end
            3, 4:
            begin
                steps.push_back(make_event(CMD_MODE, any_dial()));
                steps.push_back(make_event(CMD_DIAL, any_dial()));
                steps.push_back(make_event(CMD_MODE, any_dial()));
                steps.push_back(make_event(CMD_DIAL, short_dial()));
                steps.push_back(make_event(CMD_START, any_dial()));
            end
            5, 6:
            begin
                steps.push_back(make_event(CMD_DEFROST, any_dial()));
                if ($urandom_range(0, 2) == 0)
                    steps.push_back(make_event(CMD_DIAL, any_dial()));
                steps.push_back(make_event(CMD_START, any_dial()));
            end
            7, 8:
            begin
                steps.push_back(make_event(CMD_START, any_dial()));
                repeat ($urandom_range(0, 3))
                    steps.push_back(make_event(CMD_START, any_dial()));
            end
            default:
            begin
                repeat ($urandom_range(1, 4))
                    steps.push_back(make_event(3'($urandom_range(0, 7)), any_dial()));
            end
        endcase
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, steps.size() - 1) : -1;
        foreach (steps[i])
        begin
            if (i == cut)
            begin
                send_event(CMD_STOP, any_dial(), any_dial());
                break;
            end
            send_event(steps[i].cmd, steps[i].dial, steps[i].thaw);
        end
        // run the countdown with the odd stop, extra start or stray event
        n = 0;
        while (oven_phase == PH_COOKING && n < COOK_TICK_CAP)
        begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send_event(CMD_STOP, any_dial(), any_dial());
            else if (pick < 3)
                send_event(CMD_START, any_dial(), any_dial());
            else if (pick == 3)
                send_event(3'($urandom_range(0, 7)), any_dial(), any_dial());
            else
                send_event(CMD_TICK, any_dial(), any_dial());
            n++;
        end
        repeat ($urandom_range(0, 3))
            send_event(CMD_TICK, any_dial(), any_dial());
    endtask

    // Extremes of the settings, every button but clock, clamps, borrow and both ways cooking ends
    task automatic test_directed_events();
        send_event(CMD_TICK, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd63);     // dial ignored in idle
        send_event(CMD_START, 6'd0, 6'd0);      // quick start at half a minute
        send_event(CMD_POWER, 6'd63, 6'd0);     // ignored while cooking
        send_event(CMD_START, 6'd0, 6'd0);      // carry into minutes
        send_event(CMD_TICK, 6'd0, 6'd0);       // borrow from minutes
        send_event(CMD_DIAL, 6'd63, 6'd0);      // dial ignored while cooking
        send_event(CMD_STOP, 6'd0, 6'd0);
        send_event(CMD_DEFROST, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd0);      // dial ignored in defrost
        send_event(CMD_START, 6'd0, 6'd63);     // defrost seconds clamp high
        send_event(CMD_STOP, 6'd0, 6'd0);
        send_event(CMD_DEFROST, 6'd0, 6'd0);
        send_event(CMD_STOP, 6'd0, 6'd0);       // stop out of defrost loads low clamp
        send_event(CMD_POWER, 6'd0, 6'd0);
        send_event(CMD_MODE, 6'd0, 6'd0);       // ignored in power setup
        send_event(CMD_DIAL, 6'd63, 6'd0);      // power saturates at the top
        send_event(CMD_POWER, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd0, 6'd0);       // zero cook time
        send_event(CMD_START, 6'd0, 6'd0);
        send_event(CMD_TICK, 6'd0, 6'd0);       // already at zero: ends at once
        send_event(CMD_MODE, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd0);      // mode saturates
        send_event(CMD_MODE, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd1, 6'd0);
        send_event(CMD_START, 6'd0, 6'd0);
        send_event(CMD_TICK, 6'd0, 6'd0);       // ends on reaching zero
    endtask

    // Set the clock to the last minute of the day and tick through midnight
    task automatic test_clock_wrap();
        int i;
        send_event(CMD_CLOCK, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd0);
        send_event(CMD_CLOCK, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd0);
        send_event(CMD_DEFROST, 6'd0, 6'd0);    // ignored while setting minutes
        send_event(CMD_CLOCK, 6'd0, 6'd0);
        for (i = 0; i < 70 && !(tod_hours == 0 && tod_minutes == 0); i++)
            send_event(CMD_TICK, any_dial(), any_dial());
        send_event(CMD_TICK, 6'd0, 6'd0);
    endtask

    // Keep adding half minutes until the cook time pins at its maximum
    task automatic test_cook_time_saturation();
        int i;
        send_event(CMD_POWER, 6'd0, 6'd0);
        send_event(CMD_POWER, 6'd0, 6'd0);
        send_event(CMD_DIAL, 6'd63, 6'd0);      // cook seconds saturate
        send_event(CMD_START, 6'd0, 6'd0);
        for (i = 0; i < 250 && !(cook_min == COOK_MIN_MAX && cook_sec == SEC_MAX); i++)
            send_event(CMD_START, any_dial(), any_dial());
        send_event(CMD_START, 6'd0, 6'd0);
        send_event(CMD_TICK, 6'd0, 6'd0);
        send_event(CMD_START, 6'd0, 6'd0);
        send_event(CMD_STOP, 6'd0, 6'd0);
    endtask

    // Hold the result side off for a long stretch while events keep coming
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        long_holds_asked++;
        repeat (BURST_ITEMS)
            send_event(3'($urandom_range(0, 7)), any_dial(), any_dial());
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_sessions();
        int first;
        first = useful_items;
        while (useful_items - first < RANDOM_ITEMS)
            run_session();
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_steady_tail();
        int first;
        calm_tail = 1'b1;
        first = useful_items;
        while (useful_items - first < TAIL_ITEMS)
            run_session();
    endtask

    // Result side: random stall bursts in some windows, plus requested long hold-offs
    initial
    begin : result_sink
        int  len;
        int  cycles;
        bit  stalls_on;
        cycles    = 0;
        stalls_on = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 100 == 0)
                stalls_on = ($urandom_range(0, 2) != 0);
            if (long_holds_served != long_holds_asked)
            begin
                long_holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm_tail && stalls_on && $urandom_range(0, 4) == 0)
            begin
                len = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (len) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare every accepted result beat with the oldest expected status
    always @(posedge clk)
    begin : result_check
        mwc_res_t seen;
        mwc_res_t want;
        string    bad;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            seen.phase         = m_tdata[2:0];
            seen.clock_hours   = m_tdata[7:3];
            seen.clock_minutes = m_tdata[13:8];
            seen.cook_minutes  = m_tdata[20:14];
            seen.cook_seconds  = m_tdata[26:21];
            seen.power_level   = m_tdata[34:27];
            seen.cook_mode     = m_tdata[36:35];
            seen.heating       = m_tdata[37];
            seen.done_res      = m_tdata[38];
            if (pending_status.size() == 0)
                report_mismatch("result beat with nothing expected", '0, seen);
            else
            begin
                want = pending_status.pop_front();
                bad  = "";
                if (seen.phase !== want.phase)
                    bad = {bad, " phase"};
                if (seen.clock_hours !== want.clock_hours)
                    bad = {bad, " clock_hours"};
                if (seen.clock_minutes !== want.clock_minutes)
                    bad = {bad, " clock_minutes"};
                if (seen.cook_minutes !== want.cook_minutes)
                    bad = {bad, " cook_minutes"};
                if (seen.cook_seconds !== want.cook_seconds)
                    bad = {bad, " cook_seconds"};
                if (seen.power_level !== want.power_level)
                    bad = {bad, " power_level"};
                if (seen.cook_mode !== want.cook_mode)
                    bad = {bad, " cook_mode"};
                if (seen.heating !== want.heating)
                    bad = {bad, " heating"};
                if (seen.done_res !== want.done_res)
                    bad = {bad, " done_res"};
                if (bad != "")
                    report_mismatch({"wrong field:", bad}, want, seen);
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("microwave_oven_controller: mismatch");
        $finish;
    end

    initial
    begin
        oven_phase  = PH_IDLE;
        tod_hours   = '0;
        tod_minutes = '0;
        tod_seconds = '0;
        cook_min    = '0;
        cook_sec    = '0;
        power_set   = '0;
        mode_set    = '0;
        from_idle   = 1'b0;
        from_setup  = 1'b0;
        last_status = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_clock_wrap();
        test_cook_time_saturation();
        test_output_backpressure();
        test_random_sessions();
        test_steady_tail();
        wait_for_results();
        if (mismatch_count == 0 && pending_status.size() == 0)
            $display("microwave_oven_controller: match");
        else
            $display("microwave_oven_controller: mismatch");
        $finish;
    end

endmodule
